// ===== src/blfg_pkg.sv =====
// shared types and constants for the battery level filter and charge gauge
package blfg_pkg;

    localparam int PIN_W     = 12;
    localparam int SUM_W     = 18;
    localparam int RATIO_W   = 16;
    localparam int LEVEL_W   = 32;
    localparam int CELL_W    = 16;
    localparam int PCT_W     = 7;
    localparam int FRAC_W    = 16;

    // percent unit widths
    localparam int OFF_W     = 25;
    localparam int DP_W      = 5;
    localparam int SEG_D_W   = 9;
    localparam int PNUM_W    = 14;

    localparam logic [RATIO_W-1:0] DIVIDER_RESET = 16'd8192;
    localparam logic [RATIO_W-1:0] WEIGHT_RESET  = 16'd1311;

    // register select is paddr[2]
    localparam logic REG_DIVIDER = 1'b0;
    localparam logic REG_WEIGHT  = 1'b1;

    localparam logic MODE_SEED = 1'b0;

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    localparam int CURVE_POINTS = 8;

    // resting-voltage curve, highest point first
    localparam logic [12:0] CURVE_MV [0:CURVE_POINTS-1] = '{
        13'd4200, 13'd4000, 13'd3850, 13'd3750, 13'd3650, 13'd3500, 13'd3300, 13'd3000
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [0:CURVE_POINTS-1] = '{
        7'd100, 7'd80, 7'd60, 7'd45, 7'd30, 7'd15, 7'd5, 7'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_AVG_MUL,
        ST_AVG_DIV,
        ST_FILT_MUL,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_OUT
    } blfg_state_t;

endpackage

// ===== src/battery_level_filter_gauge_core.sv =====
// top level: config registers, averaging, exponential filter and output stage
// seed item: the 16-step serial multiply, then the 14-step percent divide, which is skipped
//   when the level is at or past a curve end
// averaging item that closes a block: two 16-step multiplies, a 38-step divide by the sample count
//   and the percent unit, whose divide is skipped when the level is at or past a curve end
// one item at a time; the next transfer can come in the cycle after the result loads
// rst_n clears the filter, sum, count and output valid, and loads the register defaults
module battery_level_filter_gauge_core #(
    parameter int SAMPLES_PER_UPDATE = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] pin_millivolts, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] cell_millivolts, [22:16] charge_percent, [23] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W   = (SAMPLES_PER_UPDATE > 1) ? $clog2(SAMPLES_PER_UPDATE) : 1;
    localparam int SDIV_W  = $clog2(SAMPLES_PER_UPDATE + 1);
    localparam int MA_W    = blfg_pkg::LEVEL_W;
    localparam int MP_W    = MA_W + blfg_pkg::RATIO_W;
    localparam int TNUM_W  = blfg_pkg::SUM_W + blfg_pkg::RATIO_W + 4;
    localparam int SEED_W  = blfg_pkg::PIN_W + blfg_pkg::RATIO_W;
    localparam int SUMP_W  = blfg_pkg::SUM_W + blfg_pkg::RATIO_W;

    blfg_pkg::blfg_state_t state_reg;
    blfg_pkg::blfg_state_t state_next;

    logic [blfg_pkg::RATIO_W-1:0] divider_reg;
    logic [blfg_pkg::RATIO_W-1:0] weight_reg;
    logic [blfg_pkg::SUM_W-1:0]   sum_reg;
    logic [blfg_pkg::SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]             count_reg;
    logic [blfg_pkg::LEVEL_W-1:0] level_reg;
    logic [blfg_pkg::LEVEL_W-1:0] level_next;
    logic                         neg_reg;
    logic                         m_tvalid_reg;
    logic [blfg_pkg::CELL_W-1:0]  cell_reg;
    logic [blfg_pkg::PCT_W-1:0]   pct_reg;

    logic                         mode;
    logic [blfg_pkg::PIN_W-1:0]   pin;
    logic                         s_accept;
    logic                         last_sample;
    logic                         cfg_write;

    logic                         mul_start;
    logic [MA_W-1:0]              mul_a;
    logic [blfg_pkg::RATIO_W-1:0] mul_b;
    logic                         mul_done;
    logic [MP_W-1:0]              mul_prod;

    logic                         div_start;
    logic                         div_done;
    logic [TNUM_W-1:0]            div_quo;

    logic                         pct_start;
    logic                         pct_done;
    logic [blfg_pkg::PCT_W-1:0]   pct_value;

    logic [blfg_pkg::LEVEL_W-1:0] target;
    logic                         target_neg;
    logic [blfg_pkg::LEVEL_W-1:0] target_mag;
    logic [blfg_pkg::LEVEL_W-1:0] filt_step;
    logic                         out_load;

    assign mode        = s_tuser[0];
    assign pin         = s_tdata[blfg_pkg::PIN_W-1:0];
    assign s_accept    = s_tvalid && s_tready;
    assign sum_next    = sum_reg + blfg_pkg::SUM_W'(pin);
    assign last_sample = (count_reg == CNT_W'(SAMPLES_PER_UPDATE - 1));

    // config port
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == blfg_pkg::REG_WEIGHT) ? {16'h0000, weight_reg}
                                                          : {16'h0000, divider_reg};

    // mean scaled by the divider, saturated to the level width
    always_comb
    begin
        target     = (|div_quo[TNUM_W-1:blfg_pkg::LEVEL_W]) ? '1
                                                            : div_quo[blfg_pkg::LEVEL_W-1:0];
        target_neg = target < level_reg;
        target_mag = target_neg ? (level_reg - target) : (target - level_reg);
        filt_step  = mul_prod[blfg_pkg::FRAC_W +: blfg_pkg::LEVEL_W];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blfg_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (mode == blfg_pkg::MODE_SEED)
                    begin
                        state_next = blfg_pkg::ST_SEED_MUL;
                    end
                    else if (last_sample)
                    begin
                        state_next = blfg_pkg::ST_AVG_MUL;
                    end
                end
            end
            blfg_pkg::ST_SEED_MUL:
            begin
                if (mul_done)
                begin
                    state_next = blfg_pkg::ST_PCT_GO;
                end
            end
            blfg_pkg::ST_AVG_MUL:
            begin
                if (mul_done)
                begin
                    state_next = blfg_pkg::ST_AVG_DIV;
                end
            end
            blfg_pkg::ST_AVG_DIV:
            begin
                if (div_done)
                begin
                    state_next = blfg_pkg::ST_FILT_MUL;
                end
            end
            blfg_pkg::ST_FILT_MUL:
            begin
                if (mul_done)
                begin
                    state_next = blfg_pkg::ST_PCT_GO;
                end
            end
            blfg_pkg::ST_PCT_GO:
            begin
                state_next = blfg_pkg::ST_PCT_WAIT;
            end
            blfg_pkg::ST_PCT_WAIT:
            begin
                if (pct_done)
                begin
                    state_next = blfg_pkg::ST_OUT;
                end
            end
            blfg_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = blfg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blfg_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        mul_a     = MA_W'(pin);
        mul_b     = divider_reg;
        div_start = 1'b0;
        pct_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            blfg_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                mul_start = s_accept && ((mode == blfg_pkg::MODE_SEED) || last_sample);
                mul_a     = (mode == blfg_pkg::MODE_SEED) ? MA_W'(pin) : MA_W'(sum_next);
            end
            blfg_pkg::ST_AVG_MUL:
            begin
                div_start = mul_done;
            end
            blfg_pkg::ST_AVG_DIV:
            begin
                mul_start = div_done;
                mul_a     = target_mag;
                mul_b     = weight_reg;
            end
            blfg_pkg::ST_PCT_GO:
            begin
                pct_start = 1'b1;
            end
            blfg_pkg::ST_OUT:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // new filter level
    always_comb
    begin
        level_next = level_reg;
        if ((state_reg == blfg_pkg::ST_SEED_MUL) && mul_done)
        begin
            level_next = {mul_prod[SEED_W-1:0], 4'h0};
        end
        else if ((state_reg == blfg_pkg::ST_FILT_MUL) && mul_done)
        begin
            // magnitude then sign, so the step truncates toward zero
            level_next = neg_reg ? (level_reg - filt_step) : (level_reg + filt_step);
        end
    end

    blfg_mul_serial #(
        .A_W (MA_W),
        .B_W (blfg_pkg::RATIO_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    blfg_div_serial #(
        .N_W (TNUM_W),
        .D_W (SDIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({mul_prod[SUMP_W-1:0], 4'h0}),
        .den   (SDIV_W'(SAMPLES_PER_UPDATE)),
        .done  (div_done),
        .quo   (div_quo)
    );

    blfg_percent u_pct (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pct_start),
        .level   (level_reg),
        .done    (pct_done),
        .percent (pct_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= blfg_pkg::ST_IDLE;
            divider_reg  <= blfg_pkg::DIVIDER_RESET;
            weight_reg   <= blfg_pkg::WEIGHT_RESET;
            sum_reg      <= '0;
            count_reg    <= '0;
            level_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            if (cfg_write)
            begin
                if (paddr[2] == blfg_pkg::REG_WEIGHT)
                begin
                    weight_reg <= pwdata[blfg_pkg::RATIO_W-1:0];
                end
                else
                begin
                    divider_reg <= pwdata[blfg_pkg::RATIO_W-1:0];
                end
            end
            if (s_accept)
            begin
                if ((mode == blfg_pkg::MODE_SEED) || last_sample)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == blfg_pkg::ST_AVG_DIV) && div_done)
        begin
            neg_reg <= target_neg;
        end
        if (out_load)
        begin
            cell_reg <= level_reg[blfg_pkg::LEVEL_W-1:blfg_pkg::FRAC_W];
            pct_reg  <= pct_value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, pct_reg, cell_reg};

endmodule

// ===== src/blfg_mul_serial.sv =====
// shift-add multiplier, one bit of the multiplier operand per cycle
module blfg_mul_serial #(
    parameter int A_W = 32,
    parameter int B_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 done,
    output logic [A_W+B_W-1:0]   prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   a_reg;
    logic [B_W-1:0]   b_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // msb first: shift the partial sum and add the operand when the bit is set
    always_comb
    begin
        acc_next = {acc_reg[P_W-2:0], 1'b0} + (b_reg[B_W-1] ? P_W'(a_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= {b_reg[B_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== src/blfg_div_serial.sv =====
// restoring divider, one quotient bit per cycle
module blfg_div_serial #(
    parameter int N_W = 38,
    parameter int D_W = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quo
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   num_reg;
    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             q_bit;
    logic [D_W-1:0]   rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_comb
    begin
        trial    = {rem_reg, num_reg[N_W-1]};
        diff     = trial - {1'b0, den_reg};
        q_bit    = (trial >= {1'b0, den_reg});
        rem_next = q_bit ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend bits shift out the top while quotient bits shift in below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[N_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

// ===== src/blfg_percent.sv =====
// piecewise-linear mapping of the filtered level to charge percent
module blfg_percent (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [blfg_pkg::LEVEL_W-1:0] level,
    output logic                         done,
    output logic [blfg_pkg::PCT_W-1:0]   percent
);

    localparam int PROD_W = blfg_pkg::OFF_W + blfg_pkg::DP_W;

    logic                          full_now;
    logic                          empty_now;
    logic [blfg_pkg::LEVEL_W-1:0]  hi_lvl;
    logic [blfg_pkg::LEVEL_W-1:0]  lo_lvl;
    logic [blfg_pkg::OFF_W-1:0]    seg_off;
    logic [blfg_pkg::DP_W-1:0]     seg_dp;
    logic [blfg_pkg::SEG_D_W-1:0]  seg_d;
    logic [blfg_pkg::PCT_W-1:0]    seg_plo;

    logic                          go_reg;
    logic                          full_reg;
    logic                          empty_reg;
    logic [blfg_pkg::OFF_W-1:0]    off_reg;
    logic [blfg_pkg::DP_W-1:0]     dp_reg;
    logic [blfg_pkg::SEG_D_W-1:0]  d_reg;
    logic [blfg_pkg::PCT_W-1:0]    plo_reg;
    logic [blfg_pkg::PCT_W-1:0]    percent_reg;
    logic                          done_reg;

    logic [PROD_W-1:0]             scaled;
    logic                          div_start;
    logic                          div_done;
    logic [blfg_pkg::PNUM_W-1:0]   div_quo;

    always_comb
    begin
        full_now  = level >= blfg_pkg::LEVEL_W'({blfg_pkg::CURVE_MV[0], 16'h0000});
        empty_now = level <= blfg_pkg::LEVEL_W'(
                        {blfg_pkg::CURVE_MV[blfg_pkg::CURVE_POINTS-1], 16'h0000});
        hi_lvl  = '0;
        lo_lvl  = '0;
        seg_off = '0;
        seg_dp  = '0;
        seg_d   = '0;
        seg_plo = '0;
        for (int i = 0; i < blfg_pkg::CURVE_POINTS - 1; i++)
        begin
            hi_lvl = blfg_pkg::LEVEL_W'({blfg_pkg::CURVE_MV[i], 16'h0000});
            lo_lvl = blfg_pkg::LEVEL_W'({blfg_pkg::CURVE_MV[i+1], 16'h0000});
            if ((level <= hi_lvl) && (level > lo_lvl))
            begin
                seg_off = blfg_pkg::OFF_W'(level - lo_lvl);
                seg_dp  = blfg_pkg::DP_W'(blfg_pkg::CURVE_PCT[i] - blfg_pkg::CURVE_PCT[i+1]);
                seg_d   = blfg_pkg::SEG_D_W'(blfg_pkg::CURVE_MV[i] - blfg_pkg::CURVE_MV[i+1]);
                seg_plo = blfg_pkg::CURVE_PCT[i+1];
            end
        end
    end

    // the offset carries 16 fraction bits and the segment width none, so drop them from the dividend
    assign scaled    = PROD_W'(off_reg) * PROD_W'(dp_reg);
    assign div_start = go_reg && !full_reg && !empty_reg;

    blfg_div_serial #(
        .N_W (blfg_pkg::PNUM_W),
        .D_W (blfg_pkg::SEG_D_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (scaled[PROD_W-1:blfg_pkg::FRAC_W]),
        .den   (d_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            go_reg   <= start;
            done_reg <= (go_reg && (full_reg || empty_reg)) || div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            full_reg  <= full_now;
            empty_reg <= empty_now;
            off_reg   <= seg_off;
            dp_reg    <= seg_dp;
            d_reg     <= seg_d;
            plo_reg   <= seg_plo;
        end
        if (go_reg && full_reg)
        begin
            percent_reg <= blfg_pkg::PCT_FULL;
        end
        else if (go_reg && empty_reg)
        begin
            percent_reg <= blfg_pkg::PCT_EMPTY;
        end
        else if (div_done)
        begin
            percent_reg <= plo_reg + div_quo[blfg_pkg::PCT_W-1:0];
        end
    end

    assign done    = done_reg;
    assign percent = percent_reg;

endmodule

// ===== tb/gauge_checker.sv =====
// checker for the battery gauge: tracks config writes, predicts results and compares them
module gauge_checker #(
    parameter int SAMPLES_PER_UPDATE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [15:0]       s_tdata,   // [11:0] pin_millivolts, [15:12] zero
    input  logic [0:0]        s_tuser,   // [0] mode
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [23:0]       m_tdata,   // [15:0] cell_millivolts, [22:16] charge_percent
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int unsigned       fail_count,
    output int unsigned       pending
);

    localparam int LIION_POINTS = 8;
    localparam int unsigned LIION_MV [0:LIION_POINTS-1] = '{
        4200, 4000, 3850, 3750, 3650, 3500, 3300, 3000
    };
    localparam int unsigned LIION_PCT [0:LIION_POINTS-1] = '{
        100, 80, 60, 45, 30, 15, 5, 0
    };

    typedef struct packed {
        logic [blfg_pkg::CELL_W-1:0] cell_mv;
        logic [blfg_pkg::PCT_W-1:0]  pct;
    } gauge_result_t;

    gauge_result_t expected_q [$];
    gauge_result_t want;

    logic [blfg_pkg::RATIO_W-1:0] ratio;
    logic [blfg_pkg::RATIO_W-1:0] weight;
    logic [blfg_pkg::SUM_W-1:0]   sum;
    logic [5:0]                   count;
    logic [blfg_pkg::LEVEL_W-1:0] level;
    logic [blfg_pkg::PIN_W-1:0]   pin;
    logic [63:0]                  target;
    longint                       diff;
    longint                       step_v;
    int unsigned                  fails = 0;

    assign fail_count = fails;

    function automatic gauge_result_t gauge_reading(input logic [blfg_pkg::LEVEL_W-1:0] lvl);
        gauge_result_t r;
        logic [63:0]   v;
        logic [63:0]   hi_mv;
        logic [63:0]   lo_mv;
        int            i;
        r.cell_mv = lvl[31:16];
        v = {32'b0, lvl};
        if (v >= (64'(LIION_MV[0]) << 16))
            r.pct = blfg_pkg::PCT_FULL;
        else if (v <= (64'(LIION_MV[LIION_POINTS-1]) << 16))
            r.pct = blfg_pkg::PCT_EMPTY;
        else
        begin
            r.pct = blfg_pkg::PCT_EMPTY;
            for (i = 0; i < LIION_POINTS - 1; i++)
            begin
                hi_mv = 64'(LIION_MV[i]) << 16;
                lo_mv = 64'(LIION_MV[i+1]) << 16;
                // segment interpolation on the full fractional level, rounded down
                if (v <= hi_mv && v > lo_mv)
                    r.pct = 7'(64'(LIION_PCT[i+1]) + ((v - lo_mv) *
                            64'(LIION_PCT[i] - LIION_PCT[i+1])) / (hi_mv - lo_mv));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_v);
        $display("checker: %s mismatch, got %0d expected %0d", what, got, exp_v);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio   = blfg_pkg::DIVIDER_RESET;
            weight  = blfg_pkg::WEIGHT_RESET;
            sum     = '0;
            count   = '0;
            level   = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == blfg_pkg::REG_DIVIDER)
                    ratio = pwdata[blfg_pkg::RATIO_W-1:0];
                else
                    weight = pwdata[blfg_pkg::RATIO_W-1:0];
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing pending, cell_millivolts",
                                    32'(m_tdata[15:0]), 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tdata[15:0] !== want.cell_mv)
                        report_mismatch("cell_millivolts", 32'(m_tdata[15:0]),
                                        32'(want.cell_mv));
                    if (m_tdata[22:16] !== want.pct)
                        report_mismatch("charge_percent", 32'(m_tdata[22:16]),
                                        32'(want.pct));
                end
            end

            if (s_tvalid && s_tready)
            begin
                pin = s_tdata[blfg_pkg::PIN_W-1:0];
                if (s_tuser[0] == blfg_pkg::MODE_SEED)
                begin
                    // seed loads the filter with the scaled reading, drops any partial average
                    level = (32'(pin) * 32'(ratio)) << 4;
                    sum   = '0;
                    count = '0;
                    expected_q.push_back(gauge_reading(level));
                end
                else
                begin
                    sum = sum + blfg_pkg::SUM_W'(pin);
                    if (int'(count) + 1 < SAMPLES_PER_UPDATE)
                        count = count + 6'd1;
                    else
                    begin
                        target = (64'(sum) * 64'(ratio) * 64'd16) / SAMPLES_PER_UPDATE;
                        if (target > 64'hFFFF_FFFF)
                            target = 64'hFFFF_FFFF;
                        diff   = longint'(target) - longint'({32'b0, level});
                        // signed division, truncated toward zero
                        step_v = (diff * longint'({48'b0, weight})) / 65536;
                        level  = 32'(longint'({32'b0, level}) + step_v);
                        sum    = '0;
                        count  = '0;
                        expected_q.push_back(gauge_reading(level));
                    end
                end
            end

            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// testbench top: clock, reset, register writes, reading stimulus and verdict
module tb;

    localparam int SAMPLES      = 8;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_ITEMS  = 305;

    localparam logic       MODE_ACCUM   = ~blfg_pkg::MODE_SEED;
    localparam logic [2:0] ADDR_DIVIDER = {blfg_pkg::REG_DIVIDER, 2'b00};
    localparam logic [2:0] ADDR_WEIGHT  = {blfg_pkg::REG_WEIGHT, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [11:0] pin_millivolts, [15:12] zero
    logic [0:0]  s_tuser;   // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [15:0] cell_millivolts, [22:16] charge_percent, [23] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycles = 0;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned cur_ratio;

    battery_level_filter_gauge_core #(
        .SAMPLES_PER_UPDATE(SAMPLES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gauge_checker #(
        .SAMPLES_PER_UPDATE(SAMPLES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    task automatic send_item(input logic mode, input logic [blfg_pkg::PIN_W-1:0] pin);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, pin};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [blfg_pkg::RATIO_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid, wait for every pending result, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly readings that land the cell voltage near a chosen point on or just past the curve
    function automatic logic [blfg_pkg::PIN_W-1:0] pick_pin(input int centre_mv);
        int p;
        if ($urandom_range(0, 99) < 25)
            return blfg_pkg::PIN_W'($urandom_range(0, 4095));
        p = (centre_mv * 4096) / int'(cur_ratio) + int'($urandom_range(0, 40)) - 20;
        if (p < 0)
            p = 0;
        if (p > 4095)
            p = 4095;
        return blfg_pkg::PIN_W'(p);
    endfunction

    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned k;
        int          centre_mv;
        int          i;
        sent = 0;
        while (sent < n_items)
        begin
            kind      = $urandom_range(0, 99);
            centre_mv = int'($urandom_range(2900, 4300));
            if (kind < 20)
            begin
                send_item(blfg_pkg::MODE_SEED, pick_pin(centre_mv));
                sent++;
            end
            else if (kind < 85)
            begin
                for (i = 0; i < SAMPLES; i++)
                    send_item(MODE_ACCUM, pick_pin(centre_mv));
                sent += SAMPLES;
            end
            else
            begin
                // partial average cut short by a seed
                k = $urandom_range(1, SAMPLES - 1);
                for (i = 0; i < int'(k); i++)
                    send_item(MODE_ACCUM, pick_pin(centre_mv));
                send_item(blfg_pkg::MODE_SEED, pick_pin(centre_mv));
                sent += k + 1;
            end
        end
    endtask

    initial
    begin
        int                           phase;
        logic [blfg_pkg::RATIO_W-1:0] new_ratio;
        logic [blfg_pkg::RATIO_W-1:0] new_weight;

        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        cur_ratio          = blfg_pkg::DIVIDER_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: field extremes and curve points
        send_item(blfg_pkg::MODE_SEED, 12'd0);
        send_item(blfg_pkg::MODE_SEED, 12'd4095);
        send_item(blfg_pkg::MODE_SEED, 12'd2100);
        send_item(blfg_pkg::MODE_SEED, 12'd1500);
        send_item(blfg_pkg::MODE_SEED, 12'd1501);
        send_item(blfg_pkg::MODE_SEED, 12'd2099);
        send_item(blfg_pkg::MODE_SEED, 12'd1875);
        send_item(blfg_pkg::MODE_SEED, 12'd1925);
        send_item(MODE_ACCUM, 12'd4095);
        send_item(MODE_ACCUM, 12'd0);
        send_item(MODE_ACCUM, 12'hAAA);
        send_item(MODE_ACCUM, 12'h555);
        send_item(MODE_ACCUM, 12'd2000);
        send_item(MODE_ACCUM, 12'd2000);
        send_item(MODE_ACCUM, 12'd2000);
        send_item(MODE_ACCUM, 12'd2000);
        // seed in the middle of an average
        send_item(MODE_ACCUM, 12'd1900);
        send_item(MODE_ACCUM, 12'd1950);
        send_item(MODE_ACCUM, 12'd2010);
        send_item(blfg_pkg::MODE_SEED, 12'd1800);
        settle();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0: begin sender_idle_pct = 7;  receiver_stall_pct = 73; end
                1: begin sender_idle_pct = 73; receiver_stall_pct = 7;  end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            case (phase)
                0: begin new_ratio = 16'd65535; new_weight = 16'd65535; end
                1: begin new_ratio = 16'd4096;  new_weight = 16'd1;     end
                // divider below unity, filter frozen
                2: begin new_ratio = 16'd2048;  new_weight = 16'd0;     end
                5:
                begin
                    new_ratio  = blfg_pkg::DIVIDER_RESET;
                    new_weight = blfg_pkg::WEIGHT_RESET;
                end
                default:
                begin
                    new_ratio  = blfg_pkg::RATIO_W'($urandom_range(4096, 65535));
                    new_weight = blfg_pkg::RATIO_W'($urandom_range(1, 65535));
                end
            endcase
            write_reg(ADDR_DIVIDER, new_ratio);
            write_reg(ADDR_WEIGHT, new_weight);
            cur_ratio = new_ratio;
            run_random(PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== battery_level_filter_gauge_core.f =====
src/blfg_pkg.sv
src/blfg_mul_serial.sv
src/blfg_div_serial.sv
src/blfg_percent.sv
src/battery_level_filter_gauge_core.sv
tb/gauge_checker.sv
tb/tb.sv
